/* design/pfx_pkg.sv */
// pfx_pkg: shared types and constants for the postfix stack evaluator
// operation and status codes, controller states, command and status structs
// no dependencies
package pfx_pkg;

    localparam int STACK_DEPTH   = 16;
    localparam int FRACTION_BITS = 16;
    localparam int WORD_W        = 32;
    localparam int OP_W          = 3;
    localparam int STATUS_W      = 3;
    localparam int DEPTH_W       = 5;
    localparam int SP_W          = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W         = $clog2(STACK_DEPTH);
    localparam int CNT_W         = $clog2(WORD_W);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH    = 3'd0,
        OP_ADD     = 3'd1,
        OP_SUB     = 3'd2,
        OP_MUL     = 3'd3,
        OP_DIV     = 3'd4,
        OP_FINISH  = 3'd5,
        OP_CLEAR   = 3'd6,
        OP_INVALID = 3'd7
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 3'd0,
        STAT_EMPTY   = 3'd1,
        STAT_ONE     = 3'd2,
        STAT_DIVZERO = 3'd3,
        STAT_FULL    = 3'd4,
        STAT_UNKNOWN = 3'd5,
        STAT_ENDNUM  = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_LOAD,
        S_MUL_SAT,
        S_DIV_RUN,
        S_DIV_SAT,
        S_COMMIT,
        S_RESULT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic    in_ready;
        logic    set_status;
        status_t status_code;
        logic    push;
        logic    clear;
        logic    exec;
        logic    mul_sat;
        logic    div_step;
        logic    div_sat;
        logic    commit;
        logic    load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        op_t  op;
        logic sp_zero;
        logic sp_one;
        logic full;
        logic top_zero;
        logic last_num;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

/* design/pfx_if.sv */
// pfx_if: valid/ready channel interfaces for the postfix stack evaluator
// pfx_in_if carries one token, pfx_out_if one result beat
// depends on pfx_pkg
interface pfx_in_if;
    logic                                valid;
    logic                                ready;
    logic [pfx_pkg::OP_W-1:0]            operation;
    logic signed [pfx_pkg::WORD_W-1:0]   value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface pfx_out_if;
    logic                                valid;
    logic                                ready;
    logic [pfx_pkg::STATUS_W-1:0]        status;
    logic signed [pfx_pkg::WORD_W-1:0]   top_value;
    logic [pfx_pkg::DEPTH_W-1:0]         stack_depth;

    modport source (output valid, output status, output top_value, output stack_depth,
                    input ready);
    modport sink   (input valid, input status, input top_value, input stack_depth,
                    output ready);
endinterface

/* design/pfx_ctrl.sv */
// pfx_ctrl: controller state machine of the postfix stack evaluator
// checks each token against the stack state and sequences the datapath
// depends on pfx_pkg
module pfx_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  pfx_pkg::dp_status_t sts,
    output pfx_pkg::cmd_t       cmd
);

    pfx_pkg::state_t  state_reg;
    pfx_pkg::state_t  state_next;
    pfx_pkg::status_t dec_status;
    logic             dec_arith;
    logic             dec_push;
    logic             dec_clear;

    // token check against the current stack
    always_comb
    begin
        dec_status = pfx_pkg::STAT_OK;
        dec_arith  = 1'b0;
        dec_push   = 1'b0;
        dec_clear  = 1'b0;
        unique case (sts.op) inside
            pfx_pkg::OP_PUSH:
            begin
                if (sts.full)
                    dec_status = pfx_pkg::STAT_FULL;
                else
                    dec_push = 1'b1;
            end
            pfx_pkg::OP_ADD, pfx_pkg::OP_SUB, pfx_pkg::OP_MUL, pfx_pkg::OP_DIV:
            begin
                if (sts.sp_zero)
                    dec_status = pfx_pkg::STAT_EMPTY;
                else if (sts.sp_one)
                    dec_status = pfx_pkg::STAT_ONE;
                else if (sts.op == pfx_pkg::OP_DIV && sts.top_zero)
                    dec_status = pfx_pkg::STAT_DIVZERO;
                else
                    dec_arith = 1'b1;
            end
            pfx_pkg::OP_FINISH:
            begin
                if (sts.last_num)
                    dec_status = pfx_pkg::STAT_ENDNUM;
            end
            pfx_pkg::OP_CLEAR:
            begin
                dec_clear = 1'b1;
            end
            default:
            begin
                dec_status = pfx_pkg::STAT_UNKNOWN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pfx_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pfx_pkg::S_IDLE:
            begin
                if (in_valid)
                    state_next = pfx_pkg::S_DECODE;
            end
            pfx_pkg::S_DECODE:
            begin
                state_next = dec_arith ? pfx_pkg::S_LOAD : pfx_pkg::S_RESULT;
            end
            pfx_pkg::S_LOAD:
            begin
                if (sts.op == pfx_pkg::OP_MUL)
                    state_next = pfx_pkg::S_MUL_SAT;
                else if (sts.op == pfx_pkg::OP_DIV)
                    state_next = pfx_pkg::S_DIV_RUN;
                else
                    state_next = pfx_pkg::S_COMMIT;
            end
            pfx_pkg::S_MUL_SAT:
            begin
                state_next = pfx_pkg::S_COMMIT;
            end
            pfx_pkg::S_DIV_RUN:
            begin
                if (sts.div_done)
                    state_next = pfx_pkg::S_DIV_SAT;
            end
            pfx_pkg::S_DIV_SAT:
            begin
                state_next = pfx_pkg::S_COMMIT;
            end
            pfx_pkg::S_COMMIT:
            begin
                state_next = pfx_pkg::S_RESULT;
            end
            pfx_pkg::S_RESULT:
            begin
                if (sts.out_free)
                    state_next = pfx_pkg::S_IDLE;
            end
            default:
            begin
                state_next = pfx_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.status_code = dec_status;
        unique case (state_reg)
            pfx_pkg::S_IDLE:
            begin
                cmd.in_ready = 1'b1;
            end
            pfx_pkg::S_DECODE:
            begin
                cmd.set_status = 1'b1;
                cmd.push       = dec_push;
                cmd.clear      = dec_clear;
            end
            pfx_pkg::S_LOAD:
            begin
                cmd.exec = 1'b1;
            end
            pfx_pkg::S_MUL_SAT:
            begin
                cmd.mul_sat = 1'b1;
            end
            pfx_pkg::S_DIV_RUN:
            begin
                cmd.div_step = 1'b1;
            end
            pfx_pkg::S_DIV_SAT:
            begin
                cmd.div_sat = 1'b1;
            end
            pfx_pkg::S_COMMIT:
            begin
                cmd.commit = 1'b1;
            end
            pfx_pkg::S_RESULT:
            begin
                cmd.load_out = sts.out_free;
            end
            default:
            begin
                cmd.in_ready = 1'b0;
            end
        endcase
    end

endmodule

/* design/pfx_dpath.sv */
// pfx_dpath: datapath of the postfix stack evaluator
// operand stack memory with the top held in a register, add/sub, multiplier,
// radix-2 restoring divider, saturation and the output register; depends on pfx_pkg
module pfx_dpath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pfx_pkg::cmd_t                       cmd,
    output pfx_pkg::dp_status_t                 sts,
    input  logic                                in_valid,
    input  logic [pfx_pkg::OP_W-1:0]            in_operation,
    input  logic signed [pfx_pkg::WORD_W-1:0]   in_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [pfx_pkg::STATUS_W-1:0]        out_status,
    output logic signed [pfx_pkg::WORD_W-1:0]   out_top_value,
    output logic [pfx_pkg::DEPTH_W-1:0]         out_stack_depth
);

    localparam int W  = pfx_pkg::WORD_W;
    localparam int PW = 2 * pfx_pkg::WORD_W;

    localparam logic signed [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

    // entries below the top; the top itself lives in top_reg
    logic signed [W-1:0] stack_mem [pfx_pkg::STACK_DEPTH];

    pfx_pkg::op_t              op_reg;
    logic signed [W-1:0]       val_reg;
    logic signed [W-1:0]       top_reg;
    logic [pfx_pkg::SP_W-1:0]  sp_reg;
    logic                      last_num_reg;
    pfx_pkg::status_t          status_reg;
    logic signed [W-1:0]       second_reg;
    logic signed [PW-1:0]      prod_reg;
    logic signed [W-1:0]       res_reg;
    logic [W-1:0]              rem_reg;
    logic [W-1:0]              quo_reg;
    logic [pfx_pkg::CNT_W-1:0] cnt_reg;
    logic                      neg_reg;
    logic                      ovf_reg;
    logic                      out_valid_reg;
    pfx_pkg::status_t          out_status_reg;
    logic signed [W-1:0]       out_top_reg;
    logic [pfx_pkg::SP_W-1:0]  out_sp_reg;

    logic [pfx_pkg::IDX_W-1:0] wr_idx;
    logic [pfx_pkg::IDX_W-1:0] rd_idx;
    logic signed [W:0]         sum_ext;
    logic signed [W-1:0]       sum_sat;
    logic [W-1:0]              mag_a;
    logic [W-1:0]              mag_b;
    logic [PW-1:0]             dividend;
    logic signed [PW-1:0]      prod_shift;
    logic signed [W-1:0]       prod_sat;
    logic [W:0]                trial;
    logic [W:0]                trial_diff;
    logic                      q_bit;
    logic signed [W-1:0]       quo_sat;

    assign wr_idx = pfx_pkg::IDX_W'(sp_reg - pfx_pkg::SP_W'(1));
    assign rd_idx = pfx_pkg::IDX_W'(sp_reg - pfx_pkg::SP_W'(2));

    assign sts.op       = op_reg;
    assign sts.sp_zero  = (sp_reg == '0);
    assign sts.sp_one   = (sp_reg == pfx_pkg::SP_W'(1));
    assign sts.full     = (sp_reg == pfx_pkg::SP_W'(pfx_pkg::STACK_DEPTH));
    assign sts.top_zero = (top_reg == '0);
    assign sts.last_num = last_num_reg;
    assign sts.div_done = (cnt_reg == '1);
    assign sts.out_free = !out_valid_reg || out_ready;

    // add / subtract with saturation
    always_comb
    begin
        if (op_reg == pfx_pkg::OP_SUB)
            sum_ext = {second_reg[W-1], second_reg} - {top_reg[W-1], top_reg};
        else
            sum_ext = {second_reg[W-1], second_reg} + {top_reg[W-1], top_reg};
        if (sum_ext[W] != sum_ext[W-1])
            sum_sat = sum_ext[W] ? SAT_MIN : SAT_MAX;
        else
            sum_sat = sum_ext[W-1:0];
    end

    // product floor-shift and saturation
    always_comb
    begin
        prod_shift = prod_reg >>> pfx_pkg::FRACTION_BITS;
        if ((&prod_shift[PW-1:W-1]) || !(|prod_shift[PW-1:W-1]))
            prod_sat = prod_shift[W-1:0];
        else
            prod_sat = prod_shift[PW-1] ? SAT_MIN : SAT_MAX;
    end

    // divider operand setup: magnitudes and scaled dividend
    always_comb
    begin
        mag_a    = second_reg[W-1] ? (~second_reg + W'(1)) : second_reg;
        mag_b    = top_reg[W-1] ? (~top_reg + W'(1)) : top_reg;
        dividend = {{W{1'b0}}, mag_a} << pfx_pkg::FRACTION_BITS;
    end

    // one restoring step: remainder shifts in the next dividend bit
    always_comb
    begin
        trial      = {rem_reg, quo_reg[W-1]};
        trial_diff = trial - {1'b0, mag_b};
        q_bit      = (trial >= {1'b0, mag_b});
    end

    // signed quotient with saturation
    always_comb
    begin
        if (ovf_reg)
            quo_sat = neg_reg ? SAT_MIN : SAT_MAX;
        else if (neg_reg)
            quo_sat = (quo_reg > {1'b1, {(W-1){1'b0}}}) ? SAT_MIN : (~quo_reg + W'(1));
        else
            quo_sat = quo_reg[W-1] ? SAT_MAX : quo_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push && sp_reg != '0)
            stack_mem[wr_idx] <= top_reg;
        second_reg <= stack_mem[rd_idx];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg        <= '0;
            last_num_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.push)
            begin
                sp_reg       <= sp_reg + pfx_pkg::SP_W'(1);
                last_num_reg <= 1'b1;
            end
            else if (cmd.clear)
            begin
                sp_reg       <= '0;
                last_num_reg <= 1'b0;
            end
            else if (cmd.commit)
            begin
                sp_reg       <= sp_reg - pfx_pkg::SP_W'(1);
                last_num_reg <= 1'b0;
            end
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && cmd.in_ready)
        begin
            op_reg  <= pfx_pkg::op_t'(in_operation);
            val_reg <= in_value;
        end
        if (cmd.set_status)
            status_reg <= cmd.status_code;
        if (cmd.push)
            top_reg <= val_reg;
        else if (cmd.commit)
            top_reg <= res_reg;
        if (cmd.exec)
        begin
            res_reg  <= sum_sat;
            prod_reg <= PW'(second_reg) * PW'(top_reg);
            rem_reg  <= dividend[PW-1:W];
            quo_reg  <= dividend[W-1:0];
            cnt_reg  <= '0;
            neg_reg  <= second_reg[W-1] ^ top_reg[W-1];
            ovf_reg  <= (dividend[PW-1:W] >= mag_b);
        end
        else if (cmd.mul_sat)
            res_reg <= prod_sat;
        else if (cmd.div_step)
        begin
            rem_reg <= q_bit ? trial_diff[W-1:0] : trial[W-1:0];
            quo_reg <= {quo_reg[W-2:0], q_bit};
            cnt_reg <= cnt_reg + pfx_pkg::CNT_W'(1);
        end
        else if (cmd.div_sat)
            res_reg <= quo_sat;
        if (cmd.load_out)
        begin
            out_status_reg <= status_reg;
            out_top_reg    <= (sp_reg != '0) ? top_reg : '0;
            out_sp_reg     <= sp_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_status      = out_status_reg;
    assign out_top_value   = out_top_reg;
    assign out_stack_depth = pfx_pkg::DEPTH_W'(out_sp_reg);

endmodule

/* design/postfix_stack_evaluator.sv */
// postfix_stack_evaluator: top level of the reverse Polish evaluator
// joins pfx_ctrl and pfx_dpath to the item and result channels
// depends on pfx_pkg, pfx_if, pfx_ctrl, pfx_dpath
//
// usage:
//   item carries one pre-split token per beat (operation, value); result
//   returns exactly one beat per token: status, top of stack after the token
//   (zero when empty) and the stack depth.
//   the stack holds up to 16 signed Q16.16 entries; arithmetic pops two and
//   pushes the saturated result, errors leave the stack unchanged.
// sequencing (controller states from acceptance to the result load):
//   push, finish, clear and error tokens: decode, then result
//   add/subtract: decode, load, commit, result; multiply: mul_sat after load
//   divide: div_run (32-step one-bit-per-cycle divider), div_sat after load
//   one token is in flight at a time; item.ready rises the cycle after the
//   result is loaded, so a new token is taken only once the last one is done.
// reset empties the stack and drops any pending result beat.
// when result is stalled, the finished beat is held in the output register
// and the next token is still accepted; that token's result waits until the
// held beat is taken.
module postfix_stack_evaluator (
    input  logic      clk,
    input  logic      rst_n,
    pfx_in_if.sink    item,
    pfx_out_if.source result
);

    pfx_pkg::cmd_t       cmd;
    pfx_pkg::dp_status_t sts;

    assign item.ready = cmd.in_ready;

    pfx_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .sts      (sts),
        .cmd      (cmd)
    );

    pfx_dpath u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .in_valid        (item.valid),
        .in_operation    (item.operation),
        .in_value        (item.value),
        .out_valid       (result.valid),
        .out_ready       (result.ready),
        .out_status      (result.status),
        .out_top_value   (result.top_value),
        .out_stack_depth (result.stack_depth)
    );

endmodule
